// ===== src/grwi_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the grid ray caster.
`default_nettype none
package grwi_pkg;

    // Map geometry and fixed-point formats.
    localparam int GRID_DIM      = 64;
    localparam int GRID_BITS     = 6;
    localparam int WALL_ID_BITS  = 8;
    localparam int POS_FRAC_BITS = 16;
    localparam int DIR_FRAC_BITS = 14;
    localparam int MAP_DEPTH     = GRID_DIM * GRID_DIM;

    localparam logic [23:0] DIST_MAX  = 24'hFF_FFFF;
    localparam logic [27:0] POS_MAX   = 28'h03F_FFFF;
    localparam logic [15:0] TEX_LIMIT =
        16'((9999 * (1 << POS_FRAC_BITS) + 9999) / 10000);
    // Direction magnitudes at or below this overflow the distance range.
    localparam logic [15:0] MAG_SAT   = 16'd64;
    localparam logic [4:0]  DIV_TOP   = 5'd30;

    // Wall sides inside one cell word.
    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_TOP    = 2'd3;

    // Face normal codes.
    localparam logic [1:0] NRM_POS_X = 2'd0;
    localparam logic [1:0] NRM_NEG_X = 2'd1;
    localparam logic [1:0] NRM_POS_Y = 2'd2;
    localparam logic [1:0] NRM_NEG_Y = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_cell;
        logic load;
        logic div_step;
        logic div_y;
        logic mul_sx;
        logic mul_sy;
        logic st_sx;
        logic st_sy;
        logic rd_cur;
        logic test1;
        logic test2;
        logic advance;
        logic mul_hx;
        logic mul_hy;
        logic st_hx;
        logic st_hy;
        logic out_hit;
        logic out_miss;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic cur_out;
        logic next_out;
        logic hit_now;
    } t_sts;

endpackage
`default_nettype wire

// ===== src/grid_ray_wall_intersection_top.sv =====
// Top level of the grid ray caster: controller and datapath.
//
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   func, origin, direction, nth, cell write
// output    out        o_out_valid / i_out_stall hit, point, distance, normal, cell, id, tex
// config    in         i_cfg_valid / o_cfg_ready index, data
//
// A write beat is taken while idle and the block stays ready.
// A cast runs reciprocal division (one quotient bit a cycle per axis), then the
// setup multiplies, then a walk step per cell visited (two map reads), and
// finally the hit point and result.
// Reset clears control and sets the configuration to a 64 by 64 grid; the map holds nothing until written.
// A stalled result beat holds; the next item is taken while it waits.
`default_nettype none
module grid_ray_wall_intersection_top
    import grwi_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_func,
    input  wire logic [21:0]        i_origin_x,
    input  wire logic [21:0]        i_origin_y,
    input  wire logic signed [15:0] i_dir_x,
    input  wire logic signed [15:0] i_dir_y,
    input  wire logic [7:0]         i_nth,
    input  wire logic [5:0]         i_cell_col,
    input  wire logic [5:0]         i_cell_row,
    input  wire logic [7:0]         i_wall_left,
    input  wire logic [7:0]         i_wall_right,
    input  wire logic [7:0]         i_wall_bottom,
    input  wire logic [7:0]         i_wall_top,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_hit,
    output logic [21:0]             o_hit_x,
    output logic [21:0]             o_hit_y,
    output logic [23:0]             o_distance,
    output logic [1:0]              o_normal_code,
    output logic [5:0]              o_hit_col,
    output logic [5:0]              o_hit_row,
    output logic [7:0]              o_wall_id,
    output logic [15:0]             o_texture_coord,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [6:0]         i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    grwi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    grwi_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_dir_x         (i_dir_x),
        .i_dir_y         (i_dir_y),
        .i_nth           (i_nth),
        .i_cell_col      (i_cell_col),
        .i_cell_row      (i_cell_row),
        .i_wall_left     (i_wall_left),
        .i_wall_right    (i_wall_right),
        .i_wall_bottom   (i_wall_bottom),
        .i_wall_top      (i_wall_top),
        .o_hit           (o_hit),
        .o_hit_x         (o_hit_x),
        .o_hit_y         (o_hit_y),
        .o_distance      (o_distance),
        .o_normal_code   (o_normal_code),
        .o_hit_col       (o_hit_col),
        .o_hit_row       (o_hit_row),
        .o_wall_id       (o_wall_id),
        .o_texture_coord (o_texture_coord)
    );

endmodule
`default_nettype wire

// ===== src/grwi_ctrl.sv =====
// Controller state machine that sequences a cast through setup, walk and report.
`default_nettype none
module grwi_ctrl
    import grwi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_func,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_stall,
    output logic      o_out_valid
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIVX, S_DIVY, S_MULX, S_MULY, S_SDY,
        S_BOUND, S_T1, S_T2, S_HX, S_HY, S_HYW, S_DONE, S_MISS
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   out_free;

    assign out_free   = !r_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_func) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DIVX;
                    end else begin
                        o_cmd.wr_cell = 1'b1;
                    end
                end
            end
            S_DIVX: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_DIVY;
            end
            S_DIVY: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_y    = 1'b1;
                if (i_sts.div_last) n_state = S_MULX;
            end
            S_MULX: begin
                o_cmd.mul_sx = 1'b1;
                n_state      = S_MULY;
            end
            S_MULY: begin
                o_cmd.st_sx  = 1'b1;
                o_cmd.mul_sy = 1'b1;
                n_state      = S_SDY;
            end
            S_SDY: begin
                o_cmd.st_sy = 1'b1;
                n_state     = S_BOUND;
            end
            S_BOUND: begin
                if (i_sts.cur_out) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = S_T1;
                end
            end
            S_T1: begin
                o_cmd.test1 = 1'b1;
                if (i_sts.hit_now) n_state = S_HX;
                else if (i_sts.next_out) n_state = S_MISS;
                else n_state = S_T2;
            end
            S_T2: begin
                o_cmd.test2 = 1'b1;
                if (i_sts.hit_now) begin
                    n_state = S_HX;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_BOUND;
                end
            end
            S_HX: begin
                o_cmd.mul_hx = 1'b1;
                n_state      = S_HY;
            end
            S_HY: begin
                o_cmd.st_hx  = 1'b1;
                o_cmd.mul_hy = 1'b1;
                n_state      = S_HYW;
            end
            S_HYW: begin
                o_cmd.st_hy = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_hit = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_MISS: begin
                if (out_free) begin
                    o_cmd.out_miss = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output beat valid: set on completion, cleared when taken.
    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_out_stall) n_valid = 1'b0;
        if (o_cmd.out_hit || o_cmd.out_miss) n_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // A result is never written over a beat that is still held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_hit || o_cmd.out_miss) |-> !(r_valid && i_out_stall))
        else $error("result loaded over a stalled beat");

    // An accepted cast keeps the input side stalled on the next cycle.
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_func) |=> o_in_stall)
        else $error("cast accepted without going busy");

    // Output valid only rises after a completion command.
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(o_cmd.out_hit || o_cmd.out_miss))
        else $error("output valid rose without a result");

endmodule
`default_nettype wire

// ===== src/grwi_dp.sv =====
// Datapath: map memory, reciprocal divider, multiplier, DDA registers and result register.
`default_nettype none
module grwi_dp
    import grwi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    input  wire logic [21:0] i_origin_x,
    input  wire logic [21:0] i_origin_y,
    input  wire logic signed [15:0] i_dir_x,
    input  wire logic signed [15:0] i_dir_y,
    input  wire logic [7:0]  i_nth,
    input  wire logic [5:0]  i_cell_col,
    input  wire logic [5:0]  i_cell_row,
    input  wire logic [7:0]  i_wall_left,
    input  wire logic [7:0]  i_wall_right,
    input  wire logic [7:0]  i_wall_bottom,
    input  wire logic [7:0]  i_wall_top,
    output logic             o_hit,
    output logic [21:0]      o_hit_x,
    output logic [21:0]      o_hit_y,
    output logic [23:0]      o_distance,
    output logic [1:0]       o_normal_code,
    output logic [5:0]       o_hit_col,
    output logic [5:0]       o_hit_row,
    output logic [7:0]       o_wall_id,
    output logic [15:0]      o_texture_coord
);

    // Clamp a hit coordinate: origin plus or minus the rounded product.
    function automatic logic [21:0] hit_coord(input logic [21:0] org, input logic neg,
                                              input logic [40:0] prod);
        logic [40:0] pr;
        logic [27:0] m;
        logic [27:0] o;
        logic [27:0] s;
        pr = prod + 41'd8192;
        m  = {1'b0, pr[40:14]};
        o  = {6'd0, org};
        if (neg) s = (o >= m) ? (o - m) : 28'd0;
        else     s = o + m;
        if (s > POS_MAX) s = POS_MAX;
        return s[21:0];
    endfunction

    // Configuration registers.
    logic [6:0] r_grid_w, r_grid_h;
    logic [6:0] eff_w, eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= 7'd64;
            r_grid_h <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_w = (r_grid_w > 7'(GRID_DIM)) ? 7'(GRID_DIM) : r_grid_w;
    assign eff_h = (r_grid_h > 7'(GRID_DIM)) ? 7'(GRID_DIM) : r_grid_h;

    // Cast registers.
    logic [21:0] r_ox, r_oy;
    logic        r_dxn, r_dyn;
    logic [15:0] r_magx, r_magy;
    logic [7:0]  r_nth;
    logic [8:0]  r_cnt;
    logic [7:0]  r_cx, r_cy, r_nx, r_ny;
    logic [23:0] r_ddx, r_ddy, r_sdx, r_sdy, r_dist;
    logic        r_ax;
    logic [15:0] r_rem;
    logic [23:0] r_quo;
    logic [4:0]  r_dcnt;
    logic [40:0] r_prod;
    logic [21:0] r_hx, r_hy;
    logic [5:0]  r_hcol, r_hrow;
    logic [7:0]  r_hid;
    logic [1:0]  r_hnorm;
    logic [31:0] r_rdata;
    logic [31:0] r_mem [0:MAP_DEPTH-1];

    // Divider step: restoring division of 2^30 by the direction magnitude.
    logic [15:0] div_mag;
    logic [16:0] div_t;
    logic        div_ge;
    logic [16:0] div_rem;
    logic [23:0] div_quo, div_res;

    assign div_mag = i_cmd.div_y ? r_magy : r_magx;
    assign div_t   = {r_rem, (r_dcnt == DIV_TOP)};
    assign div_ge  = (div_t >= {1'b0, div_mag});
    assign div_rem = div_ge ? (div_t - {1'b0, div_mag}) : div_t;
    assign div_quo = {r_quo[22:0], div_ge};
    assign div_res = (div_mag <= MAG_SAT) ? DIST_MAX : div_quo;

    // Multiplier operand selection.
    logic [16:0] mul_a;
    logic [23:0] mul_b;

    always_comb begin
        mul_a = {1'b0, r_magy};
        mul_b = r_dist;
        if (i_cmd.mul_sx) begin
            mul_a = r_dxn ? {1'b0, r_ox[15:0]} : (17'h10000 - {1'b0, r_ox[15:0]});
            mul_b = r_ddx;
        end else if (i_cmd.mul_sy) begin
            mul_a = r_dyn ? {1'b0, r_oy[15:0]} : (17'h10000 - {1'b0, r_oy[15:0]});
            mul_b = r_ddy;
        end else if (i_cmd.mul_hx) begin
            mul_a = {1'b0, r_magx};
        end
    end

    // Walk step decisions.
    logic        n_ax;
    logic [7:0]  sx, sy;
    logic [1:0]  side1, side;
    logic [7:0]  wall;
    logic        wall_nz, match;
    logic [24:0] sum_x, sum_y;

    assign n_ax  = (r_sdx < r_sdy);
    assign sx    = r_dxn ? 8'hFF : 8'h01;
    assign sy    = r_dyn ? 8'hFF : 8'h01;
    assign side1 = r_ax ? (r_dxn ? SIDE_LEFT : SIDE_RIGHT) : (r_dyn ? SIDE_BOTTOM : SIDE_TOP);
    assign side  = i_cmd.test2 ? (side1 ^ 2'd1) : side1;

    always_comb begin
        case (side)
            SIDE_LEFT:   wall = r_rdata[7:0];
            SIDE_RIGHT:  wall = r_rdata[15:8];
            SIDE_BOTTOM: wall = r_rdata[23:16];
            SIDE_TOP:    wall = r_rdata[31:24];
            default:     wall = 8'd0;
        endcase
    end

    assign wall_nz = (wall != 8'd0);
    assign match   = ((r_cnt + 9'd1) == {1'b0, r_nth});
    assign sum_x   = {1'b0, r_sdx} + {1'b0, r_ddx};
    assign sum_y   = {1'b0, r_sdy} + {1'b0, r_ddy};

    assign o_sts.div_last = (r_dcnt == 5'd0);
    assign o_sts.cur_out  = r_cx[7] || (r_cx[6:0] >= eff_w) ||
                            r_cy[7] || (r_cy[6:0] >= eff_h);
    assign o_sts.next_out = r_nx[7] || (r_nx[6:0] >= eff_w) ||
                            r_ny[7] || (r_ny[6:0] >= eff_h);
    assign o_sts.hit_now  = wall_nz && match;

    // Map memory: one write port, one registered read port.
    logic [11:0] raddr;

    assign raddr = i_cmd.rd_cur ? {r_cy[5:0], r_cx[5:0]} : {r_ny[5:0], r_nx[5:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_cell) begin
            r_mem[{i_cell_row, i_cell_col}] <=
                {i_wall_top, i_wall_bottom, i_wall_right, i_wall_left};
        end
        r_rdata <= r_mem[raddr];
    end

    // Cast datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= {24'd0, mul_a} * {17'd0, mul_b};
        if (i_cmd.load) begin
            r_ox   <= i_origin_x;
            r_oy   <= i_origin_y;
            r_dxn  <= i_dir_x[15];
            r_dyn  <= i_dir_y[15];
            r_magx <= i_dir_x[15] ? (~i_dir_x + 16'd1) : i_dir_x;
            r_magy <= i_dir_y[15] ? (~i_dir_y + 16'd1) : i_dir_y;
            r_nth  <= i_nth;
            r_cnt  <= 9'd0;
            r_cx   <= {2'b00, i_origin_x[21:16]};
            r_cy   <= {2'b00, i_origin_y[21:16]};
            r_rem  <= 16'd0;
            r_dcnt <= DIV_TOP;
        end
        if (i_cmd.div_step) begin
            if (r_dcnt == 5'd0) begin
                if (i_cmd.div_y) r_ddy <= div_res;
                else             r_ddx <= div_res;
                r_rem  <= 16'd0;
                r_dcnt <= DIV_TOP;
            end else begin
                r_rem  <= div_rem[15:0];
                r_dcnt <= r_dcnt - 5'd1;
            end
            r_quo <= div_quo;
        end
        if (i_cmd.st_sx) r_sdx <= r_prod[39:16];
        if (i_cmd.st_sy) r_sdy <= r_prod[39:16];
        // Pick the nearer side and the neighbor cell for this step.
        if (i_cmd.rd_cur) begin
            r_ax   <= n_ax;
            r_dist <= n_ax ? r_sdx : r_sdy;
            r_nx   <= n_ax ? (r_cx + sx) : r_cx;
            r_ny   <= n_ax ? r_cy : (r_cy + sy);
            r_hnorm <= n_ax ? (r_dxn ? NRM_POS_X : NRM_NEG_X)
                            : (r_dyn ? NRM_POS_Y : NRM_NEG_Y);
        end
        if ((i_cmd.test1 || i_cmd.test2) && wall_nz) begin
            r_cnt <= r_cnt + 9'd1;
            r_hid <= wall;
            r_hcol <= i_cmd.test2 ? r_nx[5:0] : r_cx[5:0];
            r_hrow <= i_cmd.test2 ? r_ny[5:0] : r_cy[5:0];
        end
        if (i_cmd.advance) begin
            if (r_ax) begin
                r_sdx <= sum_x[24] ? DIST_MAX : sum_x[23:0];
                r_cx  <= r_nx;
            end else begin
                r_sdy <= sum_y[24] ? DIST_MAX : sum_y[23:0];
                r_cy  <= r_ny;
            end
        end
        if (i_cmd.st_hx) r_hx <= hit_coord(r_ox, r_dxn, r_prod);
        if (i_cmd.st_hy) r_hy <= hit_coord(r_oy, r_dyn, r_prod);
    end

    // Texture coordinate from the hit point fractions.
    logic [15:0] fx, fy, tex;

    assign fx = r_hx[15:0];
    assign fy = r_hy[15:0];

    always_comb begin
        if (fx > fy) tex = (fx < TEX_LIMIT) ? fx : fy;
        else         tex = (fy < TEX_LIMIT) ? fy : fx;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_hit) begin
            o_hit           <= 1'b1;
            o_hit_x         <= r_hx;
            o_hit_y         <= r_hy;
            o_distance      <= r_dist;
            o_normal_code   <= r_hnorm;
            o_hit_col       <= r_hcol;
            o_hit_row       <= r_hrow;
            o_wall_id       <= r_hid;
            o_texture_coord <= tex;
        end else if (i_cmd.out_miss) begin
            o_hit           <= 1'b0;
            o_hit_x         <= '0;
            o_hit_y         <= '0;
            o_distance      <= '0;
            o_normal_code   <= '0;
            o_hit_col       <= '0;
            o_hit_row       <= '0;
            o_wall_id       <= '0;
            o_texture_coord <= '0;
        end
    end

endmodule
`default_nettype wire
